// ----- hdl/hbcq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the half block cell quantizer.
package hbcq_pkg;

    localparam int PAL_ENTRIES = 16;
    localparam int PAIR_COUNT  = 8;
    localparam int IDX_W       = 4;
    localparam int DIST_W      = 18;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    localparam logic [7:0] GLYPH_LOWER = 8'd220;
    localparam logic [7:0] GLYPH_LEFT  = 8'd221;

    typedef logic [23:0] t_colour;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [IDX_W-1:0] t_index;
    typedef t_colour [PAL_ENTRIES-1:0] t_palette;

    typedef struct packed {
        logic [23:0] bottom_right_pixel;
        logic [23:0] bottom_left_pixel;
        logic [23:0] top_right_pixel;
        logic [23:0] top_left_pixel;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] glyph;
        logic [3:0] fore_colour;
        logic [3:0] back_colour;
    } t_cell_out;

    function automatic t_colour avg2(input t_colour a, input t_colour b);
        logic [8:0] sum;
        t_colour    r;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            sum = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            r[8*k +: 8] = sum[8:1];
        end
        return r;
    endfunction

    function automatic t_dist dist2(input t_colour a, input t_colour b);
        logic [7:0]  d;
        logic [15:0] sq;
        t_dist       s;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            d = (a[8*k +: 8] > b[8*k +: 8]) ? a[8*k +: 8] - b[8*k +: 8]
                                            : b[8*k +: 8] - a[8*k +: 8];
            sq = {8'd0, d} * {8'd0, d};
            s = s + {2'b00, sq};
        end
        return s;
    endfunction

endpackage

// ----- hdl/hbcq_nearest.sv -----
`timescale 1ns / 1ps
// Three-stage nearest palette entry search: distances, then a registered minimum tree.
module hbcq_nearest (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hbcq_pkg::t_colour  i_colour,
    input  hbcq_pkg::t_palette i_palette,
    output logic              o_valid,
    output hbcq_pkg::t_index   o_index
);
    import hbcq_pkg::*;

    t_dist  r_dist [PAL_ENTRIES];
    t_dist  n_dist [PAL_ENTRIES];
    logic   r_v1, r_v2, r_v3;
    t_dist  r_qdist [4];
    t_index r_qidx  [4];
    t_dist  n_qdist [4];
    t_index n_qidx  [4];
    t_index r_index;
    t_index n_index;

    always_comb begin
        for (int i = 0; i < PAL_ENTRIES; i++) begin
            n_dist[i] = dist2(i_palette[i], i_colour);
        end
    end

    // Each compare is strict and takes the higher index only when it is strictly nearer, so ties keep the lowest index.
    always_comb begin
        t_dist  da, db;
        t_index ia, ib;
        for (int g = 0; g < 4; g++) begin
            if (r_dist[4*g+1] < r_dist[4*g]) begin
                da = r_dist[4*g+1];
                ia = IDX_W'(4*g+1);
            end else begin
                da = r_dist[4*g];
                ia = IDX_W'(4*g);
            end
            if (r_dist[4*g+3] < r_dist[4*g+2]) begin
                db = r_dist[4*g+3];
                ib = IDX_W'(4*g+3);
            end else begin
                db = r_dist[4*g+2];
                ib = IDX_W'(4*g+2);
            end
            if (db < da) begin
                n_qdist[g] = db;
                n_qidx[g]  = ib;
            end else begin
                n_qdist[g] = da;
                n_qidx[g]  = ia;
            end
        end
    end

    always_comb begin
        t_dist  da, db;
        t_index ia, ib;
        if (r_qdist[1] < r_qdist[0]) begin
            da = r_qdist[1];
            ia = r_qidx[1];
        end else begin
            da = r_qdist[0];
            ia = r_qidx[0];
        end
        if (r_qdist[3] < r_qdist[2]) begin
            db = r_qdist[3];
            ib = r_qidx[3];
        end else begin
            db = r_qdist[2];
            ib = r_qidx[2];
        end
        n_index = (db < da) ? ib : ia;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist  <= n_dist;
        r_qdist <= n_qdist;
        r_qidx  <= n_qidx;
        r_index <= n_index;
    end

    assign o_valid = r_v3;
    assign o_index = r_index;

endmodule

// ----- hdl/half_block_cell_quantizer_unit.sv -----
`timescale 1ns / 1ps
// Top level of the half block cell quantizer: averaging, split choice and palette mapping.
// The unit takes one 2x2 pixel beat in every clock cycle and never raises busy. Each cell
// appears on o_result with o_done high once its start beat has passed through a six-stage
// pipeline: channel averages, split distances, split choice, palette
// distances, and two levels of a registered minimum tree. Results cannot be held off, so
// the receiver must take each beat in the cycle it is shown. Palette writes are meant to
// happen only while no cell is in flight.
module half_block_cell_quantizer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  hbcq_pkg::t_pixel_in              i_item,
    output logic                             o_done,
    output hbcq_pkg::t_cell_out              o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hbcq_pkg::ADDR_W-1:0]      paddr,
    input  logic [hbcq_pkg::DATA_W-1:0]      pwdata,
    output logic [hbcq_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import hbcq_pkg::*;

    t_palette r_palette;
    logic     cfg_write;
    logic [2:0] cfg_idx;

    logic    accept;
    logic    r_v1, r_v2, r_v3;
    t_colour r_left1, r_right1, r_top1, r_bottom1;
    t_colour r_left2, r_right2, r_top2, r_bottom2;
    t_dist   r_dw, r_dh;
    logic    r_lower3;
    t_colour r_fore3, r_back3;
    logic [2:0] r_lower_d;

    logic   fore_valid, back_valid;
    t_index fore_idx, back_idx;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[5:3];
    assign prdata    = {16'd0, r_palette[{cfg_idx, 1'b1}], r_palette[{cfg_idx, 1'b0}]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette <= '0;
        end else if (cfg_write) begin
            r_palette[{cfg_idx, 1'b0}] <= pwdata[23:0];
            r_palette[{cfg_idx, 1'b1}] <= pwdata[47:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left1   <= avg2(i_item.top_left_pixel, i_item.bottom_left_pixel);
        r_right1  <= avg2(i_item.top_right_pixel, i_item.bottom_right_pixel);
        r_top1    <= avg2(i_item.top_left_pixel, i_item.top_right_pixel);
        r_bottom1 <= avg2(i_item.bottom_left_pixel, i_item.bottom_right_pixel);

        r_dw      <= dist2(r_left1, r_right1);
        r_dh      <= dist2(r_top1, r_bottom1);
        r_left2   <= r_left1;
        r_right2  <= r_right1;
        r_top2    <= r_top1;
        r_bottom2 <= r_bottom1;

        r_lower3  <= (r_dw < r_dh);
        r_fore3   <= (r_dw < r_dh) ? r_bottom2 : r_left2;
        r_back3   <= (r_dw < r_dh) ? r_top2 : r_right2;

        r_lower_d <= {r_lower_d[1:0], r_lower3};
    end

    hbcq_nearest u_fore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v3),
        .i_colour  (r_fore3),
        .i_palette (r_palette),
        .o_valid   (fore_valid),
        .o_index   (fore_idx)
    );

    hbcq_nearest u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v3),
        .i_colour  (r_back3),
        .i_palette (r_palette),
        .o_valid   (back_valid),
        .o_index   (back_idx)
    );

    assign o_done               = fore_valid;
    assign o_result.glyph       = r_lower_d[2] ? GLYPH_LOWER : GLYPH_LEFT;
    assign o_result.fore_colour = fore_idx;
    assign o_result.back_colour = back_idx;

    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##6 o_done)
        else $error("Accepted beat did not produce a result after six cycles.");

    a_done_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept && i_rst_n, 6))
        else $error("Result appeared without a matching accepted beat.");

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fore_valid == back_valid)
        else $error("Foreground and background searches are out of step.");

    a_glyph_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.glyph == GLYPH_LOWER || o_result.glyph == GLYPH_LEFT))
        else $error("Result carries an unknown glyph code.");

endmodule

// ----- test/hbcq_cell_checker.sv -----
`timescale 1ns / 1ps
// Cell checker for the half block cell quantizer: shadows the palette, predicts and compares.
module hbcq_cell_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  hbcq_pkg::t_pixel_in              i_item,
    input  logic                             i_done,
    input  hbcq_pkg::t_cell_out              i_result,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [hbcq_pkg::ADDR_W-1:0]      i_paddr,
    input  logic [hbcq_pkg::DATA_W-1:0]      i_pwdata,
    output int                               o_errors,
    output int                               o_pending
);
    import hbcq_pkg::*;

    t_colour   pal_shadow [PAL_ENTRIES];
    t_cell_out cells_due [$];
    int        fail_count = 0;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: cell check failed on %s: expected %0d, got %0d",
                 $time, what, want, got);
        fail_count++;
    endtask

    function automatic t_colour mean_colour(input t_colour a, input t_colour b);
        t_colour m;
        for (int k = 0; k < 3; k++) begin
            m[8*k +: 8] = 8'((int'(a[8*k +: 8]) + int'(b[8*k +: 8])) / 2);
        end
        return m;
    endfunction

    function automatic int colour_gap(input t_colour a, input t_colour b);
        int s;
        int d;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            s += d * d;
        end
        return s;
    endfunction

    // Strict comparison keeps the lowest index when several entries are equally near.
    function automatic t_index nearest_entry(input t_colour c);
        t_index best;
        int     best_gap;
        int     gap;
        best = '0;
        best_gap = colour_gap(pal_shadow[0], c);
        for (int i = 1; i < PAL_ENTRIES; i++) begin
            gap = colour_gap(pal_shadow[i], c);
            if (gap < best_gap) begin
                best_gap = gap;
                best = t_index'(i);
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        t_colour   left_c;
        t_colour   right_c;
        t_colour   top_c;
        t_colour   bottom_c;
        t_cell_out pred;
        t_cell_out want;
        int        pair;
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_ENTRIES; i++) begin
                pal_shadow[i] = '0;
            end
            cells_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                pair = int'(i_paddr[ADDR_W-1:3]);
                pal_shadow[2*pair]     = i_pwdata[23:0];
                pal_shadow[2*pair + 1] = i_pwdata[47:24];
            end
            if (i_done) begin
                if (cells_due.size() == 0) begin
                    report_mismatch("result beat with no cell due", 0, int'(i_result.glyph));
                end else begin
                    want = cells_due.pop_front();
                    if (i_result.glyph !== want.glyph)
                        report_mismatch("glyph", int'(want.glyph), int'(i_result.glyph));
                    if (i_result.fore_colour !== want.fore_colour)
                        report_mismatch("fore_colour", int'(want.fore_colour),
                                        int'(i_result.fore_colour));
                    if (i_result.back_colour !== want.back_colour)
                        report_mismatch("back_colour", int'(want.back_colour),
                                        int'(i_result.back_colour));
                end
            end
            if (i_start && !i_busy) begin
                left_c   = mean_colour(i_item.top_left_pixel, i_item.bottom_left_pixel);
                right_c  = mean_colour(i_item.top_right_pixel, i_item.bottom_right_pixel);
                top_c    = mean_colour(i_item.top_left_pixel, i_item.top_right_pixel);
                bottom_c = mean_colour(i_item.bottom_left_pixel, i_item.bottom_right_pixel);
                if (colour_gap(left_c, right_c) < colour_gap(top_c, bottom_c)) begin
                    pred.glyph       = GLYPH_LOWER;
                    pred.fore_colour = nearest_entry(bottom_c);
                    pred.back_colour = nearest_entry(top_c);
                end else begin
                    pred.glyph       = GLYPH_LEFT;
                    pred.fore_colour = nearest_entry(left_c);
                    pred.back_colour = nearest_entry(right_c);
                end
                cells_due.push_back(pred);
            end
        end
        o_pending <= cells_due.size();
        o_errors  <= fail_count;
    end

endmodule

// ----- test/tb_half_block_cell_quantizer_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the half block cell quantizer unit: stimulus, palette loads and verdict.
module tb_half_block_cell_quantizer_unit;
    import hbcq_pkg::*;

    localparam int PHASE_BLOCKS = 390;

    typedef enum int {
        BLK_NOISE,
        BLK_EXTREME,
        BLK_ROWS,
        BLK_COLUMNS,
        BLK_FLAT,
        BLK_NEAR
    } t_block_kind;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_pixel_in         i_item;
    logic              o_done;
    t_cell_out         o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                error_count;
    int                cells_pending;
    t_palette          std_palette;

    half_block_cell_quantizer_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hbcq_cell_checker u_cell_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_done    (o_done),
        .i_result  (o_result),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (error_count),
        .o_pending (cells_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (cells_pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_pair(input int pair, input logic [47:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(pair * 8);
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_palette(input t_palette pal);
        wait_idle();
        for (int k = 0; k < PAIR_COUNT; k++) begin
            write_pair(k, {pal[2*k + 1], pal[2*k]});
        end
        @(posedge i_clk);
    endtask

    task automatic push_block(input t_pixel_in blk, input int idle_pct);
        while (int'($urandom_range(99)) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= blk;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_palette random_palette();
        t_palette pal;
        for (int i = 0; i < PAL_ENTRIES; i++) begin
            pal[i] = 24'($urandom);
            if (i > 0 && $urandom_range(3) == 0) pal[i] = pal[i-1];
        end
        return pal;
    endfunction

    function automatic t_colour extreme_colour();
        t_colour c;
        for (int k = 0; k < 3; k++) begin
            c[8*k +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
        end
        return c;
    endfunction

    function automatic t_pixel_in random_block();
        t_pixel_in   blk;
        t_block_kind kind;
        t_colour     base;
        kind = t_block_kind'($urandom_range(5));
        blk  = t_pixel_in'({$urandom, $urandom, $urandom});
        case (kind)
            BLK_EXTREME: begin
                blk.top_left_pixel     = extreme_colour();
                blk.top_right_pixel    = extreme_colour();
                blk.bottom_left_pixel  = extreme_colour();
                blk.bottom_right_pixel = extreme_colour();
            end
            BLK_ROWS: begin
                blk.top_right_pixel    = blk.top_left_pixel;
                blk.bottom_right_pixel = blk.bottom_left_pixel;
            end
            BLK_COLUMNS: begin
                blk.bottom_left_pixel  = blk.top_left_pixel;
                blk.bottom_right_pixel = blk.top_right_pixel;
            end
            BLK_FLAT: begin
                blk.top_right_pixel    = blk.top_left_pixel;
                blk.bottom_left_pixel  = blk.top_left_pixel;
                blk.bottom_right_pixel = blk.top_left_pixel;
            end
            BLK_NEAR: begin
                base = blk.top_left_pixel;
                blk.top_right_pixel    = base ^ 24'($urandom_range(3) << 8*$urandom_range(2));
                blk.bottom_left_pixel  = base ^ 24'($urandom_range(3) << 8*$urandom_range(2));
                blk.bottom_right_pixel = base ^ 24'($urandom_range(3) << 8*$urandom_range(2));
            end
            default: begin
            end
        endcase
        return blk;
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        std_palette = {24'hffffff, 24'h00ff00, 24'hff00ff, 24'h555555,
                       24'hffff55, 24'h55ff55, 24'hff5555, 24'h555555,
                       24'haaaaaa, 24'h0055aa, 24'haa00aa, 24'h0000aa,
                       24'haaaa00, 24'h00aa00, 24'haa0000, 24'h000000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The palette is all zero after reset, so every colour maps to entry zero.
        push_block('0, 0);
        push_block({4{24'hffffff}}, 0);
        push_block({24'h000000, 24'h000000, 24'hffffff, 24'hffffff}, 0);

        load_palette(std_palette);
        push_block('0, 0);
        push_block({4{24'hffffff}}, 0);
        push_block({24'h000000, 24'h000000, 24'hffffff, 24'hffffff}, 0);
        push_block({24'h000000, 24'hffffff, 24'h000000, 24'hffffff}, 0);
        push_block({24'hffffff, 24'h000000, 24'h000000, 24'hffffff}, 0);
        push_block({4{24'hff00ff}}, 0);
        push_block({4{24'h00ff00}}, 0);
        push_block({24'h00ff00, 24'hff00ff, 24'h00ff00, 24'hff00ff}, 0);
        push_block({24'h00ff00, 24'h00ff00, 24'hff00ff, 24'hff00ff}, 0);
        push_block({24'h000000, 24'h000000, 24'h000000, 24'h010101}, 0);
        push_block({24'hfefefe, 24'hffffff, 24'hfefefe, 24'hffffff}, 0);
        push_block({4{24'h555555}}, 0);
        push_block({4{24'haaaaaa}}, 0);
        push_block({24'h0000ff, 24'h0000ff, 24'h000000, 24'h000000}, 0);
        push_block({24'h00ff00, 24'h000000, 24'h00ff00, 24'h000000}, 0);
        push_block({24'h808080, 24'h7f7f7f, 24'h808080, 24'h7f7f7f}, 0);

        for (int n = 0; n < PHASE_BLOCKS; n++) push_block(random_block(), 33);

        load_palette(random_palette());
        for (int n = 0; n < PHASE_BLOCKS; n++) push_block(random_block(), 79);

        load_palette({PAL_ENTRIES{24'hffffff}});
        for (int n = 0; n < 100; n++) push_block(random_block(), 0);

        load_palette(random_palette());
        for (int n = 0; n < PHASE_BLOCKS - 100; n++) push_block(random_block(), 0);

        wait_idle();
        repeat (2) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
